// ===== rtl/core/sqb_pkg.sv =====
// Package with shared types, constants and the sine table for the sprite quad batcher.
`timescale 1ns / 1ps
package sqb_pkg;

  localparam int MaxQuadsDefault     = 128;
  localparam int TextureSlotsDefault = 8;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_BIND   = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BIND,
    ST_RECORD,
    ST_MUL,
    ST_VERT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       search_step;
    logic       alloc;
    logic       empty;
    logic       quad_inc;
    logic       mul_go;
    logic       emit;
    logic [1:0] kind;
    logic [2:0] idx;
    logic [1:0] corner;
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       quads_full;
    logic       tex_zero;
    logic       hit;
    logic       search_done;
    logic       slots_full;
    logic [3:0] slots_used;
    logic       out_free;
  } stat_t;

  function automatic logic signed [15:0] quarter_sine(input logic [6:0] k);
    logic signed [15:0] v;
    case (k)
      7'd0: v = 16'sd0;      7'd1: v = 16'sd402;    7'd2: v = 16'sd804;
      7'd3: v = 16'sd1205;   7'd4: v = 16'sd1606;   7'd5: v = 16'sd2006;
      7'd6: v = 16'sd2404;   7'd7: v = 16'sd2801;   7'd8: v = 16'sd3196;
      7'd9: v = 16'sd3590;   7'd10: v = 16'sd3981;  7'd11: v = 16'sd4370;
      7'd12: v = 16'sd4756;  7'd13: v = 16'sd5139;  7'd14: v = 16'sd5520;
      7'd15: v = 16'sd5897;  7'd16: v = 16'sd6270;  7'd17: v = 16'sd6639;
      7'd18: v = 16'sd7005;  7'd19: v = 16'sd7366;  7'd20: v = 16'sd7723;
      7'd21: v = 16'sd8076;  7'd22: v = 16'sd8423;  7'd23: v = 16'sd8765;
      7'd24: v = 16'sd9102;  7'd25: v = 16'sd9434;  7'd26: v = 16'sd9760;
      7'd27: v = 16'sd10080; 7'd28: v = 16'sd10394; 7'd29: v = 16'sd10702;
      7'd30: v = 16'sd11003; 7'd31: v = 16'sd11297; 7'd32: v = 16'sd11585;
      7'd33: v = 16'sd11866; 7'd34: v = 16'sd12140; 7'd35: v = 16'sd12406;
      7'd36: v = 16'sd12665; 7'd37: v = 16'sd12916; 7'd38: v = 16'sd13160;
      7'd39: v = 16'sd13395; 7'd40: v = 16'sd13623; 7'd41: v = 16'sd13842;
      7'd42: v = 16'sd14053; 7'd43: v = 16'sd14256; 7'd44: v = 16'sd14449;
      7'd45: v = 16'sd14635; 7'd46: v = 16'sd14811; 7'd47: v = 16'sd14978;
      7'd48: v = 16'sd15137; 7'd49: v = 16'sd15286; 7'd50: v = 16'sd15426;
      7'd51: v = 16'sd15557; 7'd52: v = 16'sd15679; 7'd53: v = 16'sd15791;
      7'd54: v = 16'sd15893; 7'd55: v = 16'sd15986; 7'd56: v = 16'sd16069;
      7'd57: v = 16'sd16143; 7'd58: v = 16'sd16207; 7'd59: v = 16'sd16261;
      7'd60: v = 16'sd16305; 7'd61: v = 16'sd16340; 7'd62: v = 16'sd16364;
      7'd63: v = 16'sd16379;
      default: v = 16'sd16384;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sine_at(input logic [7:0] a);
    logic [6:0]         k;
    logic signed [15:0] v;
    k = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
    v = quarter_sine(k);
    return a[7] ? -v : v;
  endfunction

endpackage

// ===== rtl/core/sqb_if.sv =====
// Valid/ready channel interfaces for the sprite quad batcher requests and results.
`timescale 1ns / 1ps
interface sqb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] size_x;
  logic signed [31:0] size_y;
  logic [15:0]        angle;
  logic [31:0]        color;
  logic [15:0]        texture_id;
  logic [15:0]        tiling;
  modport source (output valid, command, pos_x, pos_y, pos_z, size_x, size_y, angle,
                  color, texture_id, tiling, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, size_x, size_y, angle,
                color, texture_id, tiling, output ready);
endinterface

interface sqb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic [31:0]        vert_color;
  logic [1:0]         corner;
  logic [2:0]         slot;
  logic [15:0]        vert_tiling;
  logic [15:0]        bound_texture;
  logic [9:0]         index_count;
  logic               last;
  modport source (output valid, kind, vert_x, vert_y, vert_z, vert_color, corner, slot,
                  vert_tiling, bound_texture, index_count, last, input ready);
  modport sink (input valid, kind, vert_x, vert_y, vert_z, vert_color, corner, slot,
                vert_tiling, bound_texture, index_count, last, output ready);
endinterface

// ===== rtl/core/sprite_quad_batcher.sv =====
// Top level of the sprite quad batcher: controller, datapath and checks.
//
// Requests arrive on in_* (valid/ready): begin empties the batch, draw emits four
// vertex results, first flushing the batch if its quads or slots are full, and end
// emits one bind result per used texture slot and a draw record. Results leave on
// out_* (valid/ready); the last result of a request has last set. One request is
// worked on at a time. A draw passes the slot search (skipped for a white texture),
// the corner products and then its vertex results in corner order; the next request
// is taken after the last vertex. A known texture is found by walking the used slots
// from slot 1; a new one is allocated once all used slots are searched. The sequence
// is set by the controller and the single result register.
// A stalled receiver holds the result register and the controller waits; no result
// is lost. Reset (rst_n low, synchronous) empties the batch: one slot used (white),
// no quads. The slot table holds no reset value and is only read where written.
`timescale 1ns / 1ps
module sprite_quad_batcher
  import sqb_pkg::*;
#(
  parameter int MAX_QUADS     = MaxQuadsDefault,
  parameter int TEXTURE_SLOTS = TextureSlotsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  sqb_in_if.sink    in_ch,
  sqb_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t stat;
  logic  rdy;

  sqb_ctrl #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (rdy),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sqb_dp #(.MAX_QUADS(MAX_QUADS), .TEXTURE_SLOTS(TEXTURE_SLOTS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  assign in_ch.ready = rdy;

  // A request is only taken while no result waits for the receiver, or while the waiting result is the last one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && rdy) |-> !out_ch.valid || out_ch.last)
    else $error("request taken while results pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.alloc |-> stat.slots_used < 4'(TEXTURE_SLOTS))
    else $error("slot allocated beyond table");

  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |-> stat.out_free)
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/sqb_ctrl.sv =====
// Controller state machine that sequences slot search, flushes and vertex output.
`timescale 1ns / 1ps
module sqb_ctrl
  import sqb_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TextureSlotsDefault
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t     state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] corner_r, corner_nxt;
  // Set when the flush in progress belongs to a draw request.
  logic       draw_r, draw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      corner_r <= '0;
      draw_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      corner_r <= corner_nxt;
      draw_r   <= draw_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    corner_nxt = corner_r;
    draw_nxt   = draw_r;
    ctrl       = '0;
    ctrl.idx   = idx_r;
    ctrl.corner = corner_r;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          idx_nxt   = 3'd1;
          case (stat.cmd)
            CMD_BEGIN: ctrl.empty = 1'b1;
            CMD_DRAW: begin
              draw_nxt  = 1'b1;
              idx_nxt   = 3'd0;
              state_nxt = ST_SEARCH;
            end
            CMD_END: begin
              draw_nxt  = 1'b0;
              idx_nxt   = 3'd0;
              state_nxt = ST_BIND;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        // The quad limit is checked before the slot search.
        if (stat.quads_full) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_BIND;
        end else if (stat.tex_zero || stat.hit) begin
          state_nxt = ST_MUL;
        end else if (!stat.search_done) begin
          ctrl.search_step = 1'b1;
        end else if (stat.slots_full) begin
          idx_nxt   = 3'd0;
          state_nxt = ST_BIND;
        end else begin
          ctrl.alloc = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_BIND: begin
        ctrl.kind = KIND_BIND;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          if ({1'b0, idx_r} + 4'd1 >= stat.slots_used) state_nxt = ST_RECORD;
          else idx_nxt = idx_r + 3'd1;
        end
      end
      ST_RECORD: begin
        ctrl.kind = KIND_DRAW;
        ctrl.last = !draw_r;
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          if (draw_r) begin
            ctrl.empty = 1'b1;
            idx_nxt    = 3'd0;
            state_nxt  = ST_SEARCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL: begin
        ctrl.mul_go = 1'b1;
        corner_nxt  = 2'd0;
        state_nxt   = ST_VERT;
      end
      ST_VERT: begin
        ctrl.kind = KIND_VERTEX;
        ctrl.last = (corner_r == 2'd3);
        if (stat.out_free) begin
          ctrl.emit  = 1'b1;
          corner_nxt = corner_r + 2'd1;
          if (corner_r == 2'd3) begin
            ctrl.quad_inc = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/sqb_dp.sv =====
// Datapath with slot table, batch counters, corner products and the result register.
`timescale 1ns / 1ps
module sqb_dp
  import sqb_pkg::*;
#(
  parameter int MAX_QUADS     = MaxQuadsDefault,
  parameter int TEXTURE_SLOTS = TextureSlotsDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  sqb_in_if.sink        in_ch,
  sqb_out_if.source     out_ch,
  input  ctrl_t         ctrl,
  output stat_t         stat
);

  localparam logic [7:0] MaxQ  = 8'(MAX_QUADS);
  localparam logic [3:0] SlotN = 4'(TEXTURE_SLOTS);

  logic [1:0]         cmd_r;
  logic signed [31:0] px_r, py_r, pz_r, sx_r, sy_r;
  logic signed [15:0] sn_r, cs_r;
  logic [31:0]        color_r;
  logic [15:0]        tex_r, tiling_r;
  logic [15:0]        slot_table [8];
  logic [3:0]         slots_used_r;
  logic [7:0]         quad_count_r;
  logic [2:0]         scan_r;
  logic [2:0]         slot_r;
  logic               hit_r;
  logic signed [47:0] xc_r, xs_r, yc_r, ys_r;

  logic               ov_r;
  logic [1:0]         kind_r, corner_o_r;
  logic signed [31:0] vx_r, vy_r, vz_r;
  logic [31:0]        vcol_r;
  logic [2:0]         oslot_r;
  logic [15:0]        vtil_r, bound_r;
  logic [9:0]         icnt_r;
  logic               last_r;

  logic               sgx, sgy;
  logic signed [49:0] sum_x, sum_y;
  logic signed [31:0] vx_nxt, vy_nxt;
  logic [10:0]        cnt6;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= in_ch.command;
      px_r     <= in_ch.pos_x;
      py_r     <= in_ch.pos_y;
      pz_r     <= in_ch.pos_z;
      sx_r     <= in_ch.size_x;
      sy_r     <= in_ch.size_y;
      sn_r     <= sine_at(in_ch.angle[15:8]);
      cs_r     <= sine_at(in_ch.angle[15:8] + 8'd64);
      color_r  <= in_ch.color;
      tex_r    <= in_ch.texture_id;
      tiling_r <= in_ch.tiling;
    end
    if (ctrl.alloc) slot_table[slots_used_r[2:0]] <= tex_r;
    if (ctrl.mul_go) begin
      xc_r <= sx_r * cs_r;
      xs_r <= sx_r * sn_r;
      yc_r <= sy_r * cs_r;
      ys_r <= sy_r * sn_r;
    end
  end

  // Slot search walks one entry per cycle starting from slot 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= 4'd1;
      quad_count_r <= '0;
      scan_r       <= 3'd1;
      slot_r       <= '0;
      hit_r        <= 1'b0;
    end else begin
      if (ctrl.load || ctrl.empty) begin
        scan_r <= 3'd1;
        slot_r <= '0;
        hit_r  <= 1'b0;
      end else if (ctrl.search_step) begin
        if (slot_table[scan_r] == tex_r) begin
          hit_r  <= 1'b1;
          slot_r <= scan_r;
        end else begin
          scan_r <= scan_r + 3'd1;
        end
      end
      if (ctrl.alloc) begin
        slot_r       <= slots_used_r[2:0];
        slots_used_r <= slots_used_r + 4'd1;
      end
      if (ctrl.empty) begin
        slots_used_r <= 4'd1;
        quad_count_r <= '0;
      end else if (ctrl.quad_inc) begin
        quad_count_r <= quad_count_r + 8'd1;
      end
    end
  end

  always_comb begin
    stat.cmd         = in_ch.command;
    stat.quads_full  = (cmd_r == CMD_DRAW) && (quad_count_r >= MaxQ);
    stat.tex_zero    = (tex_r == 16'd0);
    stat.hit         = hit_r;
    stat.search_done = ({1'b0, scan_r} >= slots_used_r) || ({1'b0, scan_r} >= SlotN)
                       || (scan_r == 3'd0);
    stat.slots_full  = (slots_used_r >= SlotN);
    stat.slots_used  = (slots_used_r > SlotN) ? SlotN : slots_used_r;
    stat.out_free    = !ov_r || out_ch.ready;
  end

  always_comb begin
    sgx    = (ctrl.corner == 2'd1) || (ctrl.corner == 2'd2);
    sgy    = ctrl.corner[1];
    sum_x  = (sgx ? 50'(xc_r) : -50'(xc_r)) - (sgy ? 50'(ys_r) : -50'(ys_r));
    sum_y  = (sgx ? 50'(xs_r) : -50'(xs_r)) + (sgy ? 50'(yc_r) : -50'(yc_r));
    // Arithmetic shift after adding half gives round half up.
    sum_x  = ((sum_x + 50'sd16384) >>> 15) + 50'(px_r);
    sum_y  = ((sum_y + 50'sd16384) >>> 15) + 50'(py_r);
    vx_nxt = (sum_x > 50'sd2147483647) ? 32'sh7fffffff :
             (sum_x < -50'sd2147483648) ? 32'sh80000000 : sum_x[31:0];
    vy_nxt = (sum_y > 50'sd2147483647) ? 32'sh7fffffff :
             (sum_y < -50'sd2147483648) ? 32'sh80000000 : sum_y[31:0];
    cnt6   = 11'(quad_count_r) * 11'd6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ctrl.emit) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
    if (ctrl.emit) begin
      kind_r     <= ctrl.kind;
      last_r     <= ctrl.last;
      vx_r       <= '0;
      vy_r       <= '0;
      vz_r       <= '0;
      vcol_r     <= '0;
      corner_o_r <= '0;
      oslot_r    <= '0;
      vtil_r     <= '0;
      bound_r    <= '0;
      icnt_r     <= '0;
      case (ctrl.kind)
        KIND_VERTEX: begin
          vx_r       <= vx_nxt;
          vy_r       <= vy_nxt;
          vz_r       <= pz_r;
          vcol_r     <= color_r;
          corner_o_r <= ctrl.corner;
          oslot_r    <= slot_r;
          vtil_r     <= tiling_r;
        end
        KIND_BIND: begin
          oslot_r <= ctrl.idx;
          bound_r <= (ctrl.idx == 3'd0) ? 16'd0 : slot_table[ctrl.idx];
        end
        KIND_DRAW: icnt_r <= (cnt6 > 11'd1023) ? 10'd1023 : cnt6[9:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.vert_x        = vx_r;
  assign out_ch.vert_y        = vy_r;
  assign out_ch.vert_z        = vz_r;
  assign out_ch.vert_color    = vcol_r;
  assign out_ch.corner        = corner_o_r;
  assign out_ch.slot          = oslot_r;
  assign out_ch.vert_tiling   = vtil_r;
  assign out_ch.bound_texture = bound_r;
  assign out_ch.index_count   = icnt_r;
  assign out_ch.last          = last_r;

endmodule
